>>> hdl/veo_pkg.sv
// Shared constants and types for the vertical edge outliner.
// This file has no dependencies. All other files of the block import it.
package veo_pkg;

    localparam int MAX_LINE_WIDTH_DEF = 1024;

    localparam int LINE_WIDTH_W = 11;
    localparam int DIFF_LIMIT_W = 8;
    localparam int CHAN_W       = 8;
    localparam int PIXEL_W      = 4 * CHAN_W;
    localparam int RGB_W        = 3 * CHAN_W;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = LINE_WIDTH_W;

    localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_LIMIT = 1'b1;

    localparam logic [LINE_WIDTH_W-1:0] LINE_WIDTH_RST = 11'd640;
    localparam logic [DIFF_LIMIT_W-1:0] DIFF_LIMIT_RST = 8'd10;

    localparam logic [CHAN_W-1:0] CHAN_WHITE = 8'hFF;
    localparam logic [CHAN_W-1:0] CHAN_BLACK = 8'h00;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef enum logic {
        ACT_PIXEL = 1'b0,
        ACT_DRAIN = 1'b1
    } veo_action_t;

    typedef struct packed {
        logic               drain;
        logic               have_above;
        logic               last;
        logic [RGB_W-1:0]   cur_rgb;
        logic [PIXEL_W-1:0] above;
    } veo_entry_t;

endpackage

>>> hdl/veo_front.sv
// Front end: accepts words, tracks the column and row state, and owns the line store.
// Each accepted word reads the pixel above it; words that yield a result go to the queue.
// Depends on veo_pkg.
module veo_front
    import veo_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [LINE_WIDTH_W-1:0] line_width,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [PIXEL_W-1:0]      s_tdata,   // red, green, blue, alpha
    input  logic                    s_tuser,   // action
    input  logic [QCNT_W-1:0]       q_count,
    output logic                    push_valid,
    output veo_entry_t              push_entry
);

    localparam int COL_W = $clog2(MAX_LINE_WIDTH);
    localparam int CMP_W = ((LINE_WIDTH_W > COL_W) ? LINE_WIDTH_W : COL_W) + 2;
    localparam logic [CMP_W-1:0] MAX_W = CMP_W'(MAX_LINE_WIDTH);

    logic [PIXEL_W-1:0] row_store [MAX_LINE_WIDTH];

    logic [COL_W-1:0]   col_count_reg, col_count_next;
    logic               have_above_reg, have_above_next;
    logic               s1_valid_reg, s1_valid_next;
    logic               s1_drain_reg;
    logic               s1_have_reg;
    logic               s1_last_reg;
    logic [RGB_W-1:0]   s1_rgb_reg;
    logic [PIXEL_W-1:0] above_reg;

    logic [CMP_W-1:0]   lw_ext;
    logic [CMP_W-1:0]   eff_width;
    logic [CMP_W-1:0]   col_ext;
    logic [CMP_W-1:0]   col_cur;
    logic [COL_W-1:0]   idx;
    logic               last;
    logic               accept;
    logic               is_drain;

    always_comb begin
        lw_ext = CMP_W'(line_width);
        if (lw_ext == '0) begin
            eff_width = CMP_W'(1);
        end else if (lw_ext > MAX_W) begin
            eff_width = MAX_W;
        end else begin
            eff_width = lw_ext;
        end
        col_ext = CMP_W'(col_count_reg);
        col_cur = (col_ext >= eff_width) ? (eff_width - CMP_W'(1)) : col_ext;
        idx     = col_cur[COL_W-1:0];
        last    = ((col_cur + CMP_W'(1)) >= eff_width);
    end

    assign is_drain = (veo_action_t'(s_tuser) == ACT_DRAIN);
    assign s_tready = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(s1_valid_reg))
                      < (QCNT_W+1)'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        col_count_next  = col_count_reg;
        have_above_next = have_above_reg;
        s1_valid_next   = 1'b0;
        if (accept) begin
            s1_valid_next = is_drain || have_above_reg;
            if (last) begin
                col_count_next  = '0;
                have_above_next = !is_drain;
            end else begin
                col_count_next = COL_W'(col_cur + CMP_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg  <= '0;
            have_above_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end else begin
            col_count_reg  <= col_count_next;
            have_above_reg <= have_above_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_drain_reg <= is_drain;
            s1_have_reg  <= have_above_reg;
            s1_last_reg  <= last;
            s1_rgb_reg   <= s_tdata[RGB_W-1:0];
        end
    end

    // Read-first line store: the read returns the pixel of the row above.
    always_ff @(posedge aclk) begin
        if (accept) begin
            above_reg <= row_store[idx];
            if (!is_drain) begin
                row_store[idx] <= s_tdata;
            end
        end
    end

    always_comb begin
        push_valid            = s1_valid_reg;
        push_entry.drain      = s1_drain_reg;
        push_entry.have_above = s1_have_reg;
        push_entry.last       = s1_last_reg;
        push_entry.cur_rgb    = s1_rgb_reg;
        push_entry.above      = above_reg;
    end

endmodule

>>> hdl/veo_queue.sv
// Short queue between the front end and the back end.
// Holds pending work entries so that either side can stall on its own. Depends on veo_pkg.
module veo_queue
    import veo_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  veo_entry_t        push_entry,
    output logic              pop_valid,
    input  logic              pop_ready,
    output veo_entry_t        pop_entry,
    output logic [QCNT_W-1:0] count
);

    veo_entry_t        entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              pop;

    assign pop_valid = (count_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_entry = entries[rd_ptr_reg];
    assign count     = count_reg;

    always_comb begin
        wr_ptr_next = push_valid ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push_valid) - QCNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            entries[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> hdl/veo_back.sv
// Back end: compares each queued pixel with the pixel above and forms the output word.
// Ends in an output register that loads whenever it is empty or being taken. Depends on veo_pkg.
module veo_back
    import veo_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic [DIFF_LIMIT_W-1:0] diff_limit,
    input  logic                    pop_valid,
    output logic                    pop_ready,
    input  veo_entry_t              pop_entry,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [PIXEL_W-1:0]      m_tdata,   // red, green, blue, alpha
    output logic                    m_tlast    // frame_end
);

    function automatic logic chan_differs(input logic [CHAN_W-1:0] a,
                                          input logic [CHAN_W-1:0] b,
                                          input logic [DIFF_LIMIT_W-1:0] lim);
        logic [CHAN_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return (d >= lim);
    endfunction

    logic               m_valid_reg, m_valid_next;
    logic [PIXEL_W-1:0] m_data_reg, m_data_next;
    logic               m_last_reg, m_last_next;
    logic               load;
    logic               edge_found;
    logic [CHAN_W-1:0]  edge_value;

    assign pop_ready = !m_valid_reg || m_tready;
    assign load      = pop_valid && pop_ready;

    always_comb begin
        edge_found =
            chan_differs(pop_entry.above[CHAN_W-1:0],
                         pop_entry.cur_rgb[CHAN_W-1:0], diff_limit) ||
            chan_differs(pop_entry.above[2*CHAN_W-1:CHAN_W],
                         pop_entry.cur_rgb[2*CHAN_W-1:CHAN_W], diff_limit) ||
            chan_differs(pop_entry.above[3*CHAN_W-1:2*CHAN_W],
                         pop_entry.cur_rgb[3*CHAN_W-1:2*CHAN_W], diff_limit);
        edge_value = edge_found ? CHAN_BLACK : CHAN_WHITE;

        m_data_next = m_data_reg;
        m_last_next = m_last_reg;
        if (load) begin
            m_data_next[PIXEL_W-1:RGB_W] = pop_entry.above[PIXEL_W-1:RGB_W];
            if (pop_entry.drain) begin
                m_last_next = pop_entry.last;
                if (pop_entry.have_above) begin
                    m_data_next[RGB_W-1:0] = {CHAN_WHITE, CHAN_WHITE, CHAN_WHITE};
                end else begin
                    m_data_next[RGB_W-1:0] = pop_entry.above[RGB_W-1:0];
                end
            end else begin
                m_last_next            = 1'b0;
                m_data_next[RGB_W-1:0] = {edge_value, edge_value, edge_value};
            end
        end

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> hdl/vertical_edge_outline.sv
// Vertical edge outliner: top level with configuration registers, front end, queue, back end.
// A result passes the front-end stage register, the queue and the output register in order.
// Throughput: one word per cycle when the queue has room; the line store reads and writes once.
// Reset (aresetn low, synchronous) clears column, row and queue state and the output valid.
// The line store is not cleared; the user must see that entries are read only after being
// written; the block does not enforce this. Depends on veo_pkg, veo_front, veo_queue, veo_back.
module vertical_edge_outline
    import veo_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = MAX_LINE_WIDTH_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [PIXEL_W-1:0]    s_tdata,   // in_red, in_green, in_blue, in_alpha
    input  logic                  s_tuser,   // action
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [PIXEL_W-1:0]    m_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic                  m_tlast    // frame_end
);

    logic [LINE_WIDTH_W-1:0] line_width_reg, line_width_next;
    logic [DIFF_LIMIT_W-1:0] diff_limit_reg, diff_limit_next;
    logic                    cfg_write;

    logic              push_valid;
    veo_entry_t        push_entry;
    logic              pop_valid;
    logic              pop_ready;
    veo_entry_t        pop_entry;
    logic [QCNT_W-1:0] q_count;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_comb begin
        line_width_next = line_width_reg;
        diff_limit_next = diff_limit_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                CFG_LINE_WIDTH: line_width_next = cfg_data;
                CFG_DIFF_LIMIT: diff_limit_next = cfg_data[DIFF_LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= LINE_WIDTH_RST;
            diff_limit_reg <= DIFF_LIMIT_RST;
        end else begin
            line_width_reg <= line_width_next;
            diff_limit_reg <= diff_limit_next;
        end
    end

    veo_front #(
        .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .line_width (line_width_reg),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_count    (q_count),
        .push_valid (push_valid),
        .push_entry (push_entry)
    );

    veo_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .count      (q_count)
    );

    veo_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .diff_limit (diff_limit_reg),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("queue written while full");

    a_queue_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_no_output_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !s_tready)
        else $error("input taken while queue full");

endmodule

>>> verif/tb_vertical_edge_outline.sv
// Self-checking testbench for vertical_edge_outline: drives pixel words in raster order,
// predicts every emitted word and compares it field by field on the output stream.
// Depends on veo_pkg and the vertical_edge_outline RTL.
`timescale 1ns / 100ps

module tb_vertical_edge_outline;
    import veo_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_WORDS = 1750;

    typedef struct packed {
        veo_action_t       action;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } pixel_in_t;

    typedef struct packed {
        logic              frame_end;
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } outline_px_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_LINE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [PIXEL_W-1:0]    s_tdata = '0;   // in_red, in_green, in_blue, in_alpha
    logic                  s_tuser = ACT_PIXEL;   // action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [PIXEL_W-1:0]    m_tdata;   // out_red, out_green, out_blue, out_alpha
    logic                  m_tlast;   // frame_end

    vertical_edge_outline dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Register copies: the width serves the planner and the predictor, the limit the predictor.
    logic [LINE_WIDTH_W-1:0] cur_width = LINE_WIDTH_RST;
    logic [DIFF_LIMIT_W-1:0] cur_limit = DIFF_LIMIT_RST;

    // Predictor state, advanced on every accepted word.
    logic [PIXEL_W-1:0] row_pixels [MAX_LINE_WIDTH_DEF];
    int unsigned        col_now = 0;
    bit                 above_valid = 1'b0;

    // Planner state, advanced as words are queued.
    bit                 row_filled [MAX_LINE_WIDTH_DEF];
    int unsigned        plan_col = 0;
    bit                 plan_above = 1'b0;
    int unsigned        planned = 0;
    logic [RGB_W-1:0]   tone = '0;

    pixel_in_t          pixel_queue [$];
    outline_px_t        outline_due [$];
    pixel_in_t          in_flight;
    bit                 no_idle = 1'b0;
    int                 mismatches = 0;
    int unsigned        cycles = 0;

    function automatic int unsigned row_len();
        if (cur_width == 0)
            return 1;
        if (cur_width > MAX_LINE_WIDTH_DEF)
            return MAX_LINE_WIDTH_DEF;
        return cur_width;
    endfunction

    function automatic bit far_apart(input logic [CHAN_W-1:0] a, input logic [CHAN_W-1:0] b);
        return ((a >= b) ? a - b : b - a) >= cur_limit;
    endfunction

    function automatic bit outline_predict(input pixel_in_t w, output outline_px_t o);
        int unsigned        width;
        int unsigned        col;
        bit                 last;
        bit                 marked;
        bit                 had_above;
        logic [PIXEL_W-1:0] above_px;
        logic [CHAN_W-1:0]  shade;
        width = row_len();
        col = (col_now >= width) ? width - 1 : col_now;
        last = (col + 1 >= width);
        had_above = above_valid;
        above_px = row_pixels[col];
        o.alpha = above_px[31:24];
        o.frame_end = 1'b0;
        if (w.action == ACT_DRAIN) begin
            o.red   = above_valid ? CHAN_WHITE : above_px[7:0];
            o.green = above_valid ? CHAN_WHITE : above_px[15:8];
            o.blue  = above_valid ? CHAN_WHITE : above_px[23:16];
            o.frame_end = last;
            col_now = last ? 0 : col + 1;
            if (last)
                above_valid = 1'b0;
            return 1'b1;
        end
        marked = far_apart(above_px[7:0], w.red) || far_apart(above_px[15:8], w.green) ||
                 far_apart(above_px[23:16], w.blue);
        shade = marked ? CHAN_BLACK : CHAN_WHITE;
        o.red = shade;
        o.green = shade;
        o.blue = shade;
        row_pixels[col] = {w.alpha, w.blue, w.green, w.red};
        col_now = last ? 0 : col + 1;
        if (last)
            above_valid = 1'b1;
        return had_above;
    endfunction

    always @(posedge aclk) begin : drive_pixels
        outline_px_t res;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                if (outline_predict(in_flight, res))
                    outline_due.push_back(res);
            end
            if (pixel_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 32)) begin
                in_flight = pixel_queue.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {in_flight.alpha, in_flight.blue, in_flight.green, in_flight.red};
                s_tuser <= in_flight.action;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string what, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : watch_outline
        outline_px_t want;
        outline_px_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tlast, m_tdata};
                if (outline_due.size() == 0) begin
                    $display("%0t: word %h last %b arrived, none expected, got it anyway",
                             $time, m_tdata, m_tlast);
                    mismatches++;
                end else begin
                    want = outline_due.pop_front();
                    check_field("red", want.red, got.red);
                    check_field("green", want.green, got.green);
                    check_field("blue", want.blue, got.blue);
                    check_field("alpha", want.alpha, got.alpha);
                    check_field("frame_end", want.frame_end, got.frame_end);
                end
            end
            m_tready <= no_idle || ($urandom_range(0, 99) >= 32);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LINE_WIDTH: cur_width = val[LINE_WIDTH_W-1:0];
            CFG_DIFF_LIMIT: cur_limit = val[DIFF_LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic settle();
        do @(posedge aclk);
        while (pixel_queue.size() != 0 || s_tvalid || outline_due.size() != 0);
        repeat (8) @(posedge aclk);
    endtask

    function automatic int unsigned plan_slot();
        return (plan_col >= row_len()) ? row_len() - 1 : plan_col;
    endfunction

    function automatic bit drain_ok();
        return row_filled[plan_slot()];
    endfunction

    task automatic plan_word(input pixel_in_t w);
        int unsigned col;
        bit          last;
        col = plan_slot();
        last = (col + 1 >= row_len());
        if (w.action == ACT_PIXEL)
            row_filled[col] = 1'b1;
        if (last) begin
            plan_col = 0;
            plan_above = (w.action == ACT_PIXEL);
        end else begin
            plan_col = col + 1;
        end
        planned++;
        pixel_queue.push_back(w);
    endtask

    task automatic queue_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                               input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] a);
        pixel_in_t w;
        w.action = ACT_PIXEL;
        w.red = r;
        w.green = g;
        w.blue = b;
        w.alpha = a;
        plan_word(w);
    endtask

    task automatic queue_drain();
        pixel_in_t w;
        w = {ACT_DRAIN, 8'($urandom), RGB_W'($urandom)};
        plan_word(w);
    endtask

    task automatic queue_random_pixel();
        logic [CHAN_W-1:0] ch [3];
        for (int i = 0; i < 3; i++)
            ch[i] = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom)
                    : CHAN_W'(tone[8*i +: 8] + $urandom_range(0, 15) - 8);
        queue_pixel(ch[0], ch[1], ch[2], CHAN_W'($urandom));
    endtask

    // Drains up to the end of the frame; where a slot was never written, a pixel goes in its place.
    task automatic finish_frame();
        do begin
            if (drain_ok())
                queue_drain();
            else
                queue_random_pixel();
        end while (plan_col != 0 || plan_above);
    endtask

    task automatic random_frame();
        int unsigned rows;
        rows = $urandom_range(1, 4);
        tone = RGB_W'($urandom);
        if ($urandom_range(0, 9) != 0) begin
            repeat (rows * row_len()) begin
                if ($urandom_range(0, 15) == 0 && drain_ok())
                    queue_drain();
                queue_random_pixel();
            end
        end
        finish_frame();
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        case ($urandom_range(0, 19))
            0: return '0;
            1: return CFG_DATA_W'(1);
            2: return CFG_DATA_W'($urandom_range(17, 40));
            default: return CFG_DATA_W'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic logic [DIFF_LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 8'hFF;
            2: return DIFF_LIMIT_W'(1);
            3: return DIFF_LIMIT_W'($urandom);
            default: return DIFF_LIMIT_W'($urandom_range(2, 40));
        endcase
    endfunction

    initial begin : stimulus
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        write_reg(CFG_LINE_WIDTH, 3);
        write_reg(CFG_DIFF_LIMIT, 10);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h00);
        queue_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        queue_pixel(8'h0A, 8'h14, 8'h1E, 8'hA5);
        queue_pixel(8'h09, 8'h09, 8'h09, 8'h01);
        queue_pixel(8'hFF, 8'hF5, 8'hFF, 8'h02);
        queue_pixel(8'h0A, 8'h14, 8'h28, 8'h03);
        repeat (3) queue_drain();
        queue_pixel(8'h12, 8'h34, 8'h56, 8'h78);
        queue_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
        queue_pixel(8'h01, 8'h02, 8'h03, 8'h04);
        repeat (3) queue_drain();
        repeat (3) queue_drain();
        queue_pixel(8'h07, 8'h07, 8'h07, 8'h07);
        repeat (2) queue_drain();
        settle();

        write_reg(CFG_LINE_WIDTH, 0);
        write_reg(CFG_DIFF_LIMIT, 0);
        queue_pixel(8'd50, 8'd60, 8'd70, 8'd80);
        queue_pixel(8'd50, 8'd60, 8'd70, 8'd81);
        queue_drain();
        settle();

        write_reg(CFG_LINE_WIDTH, 1);
        write_reg(CFG_DIFF_LIMIT, 11'h7FF);
        queue_pixel(8'h00, 8'h00, 8'h00, 8'h01);
        queue_pixel(8'hFF, 8'h00, 8'h00, 8'h02);
        queue_pixel(8'hFF, 8'h00, 8'h00, 8'h03);
        queue_drain();
        settle();

        // Full-width row, then a narrower width while the second row is under way.
        write_reg(CFG_LINE_WIDTH, 11'h7FF);
        write_reg(CFG_DIFF_LIMIT, 1);
        tone = RGB_W'($urandom);
        repeat (MAX_LINE_WIDTH_DEF + 5) queue_random_pixel();
        settle();
        write_reg(CFG_LINE_WIDTH, 4);
        repeat (5) queue_random_pixel();
        finish_frame();
        settle();

        for (int ph = 0; planned < RANDOM_WORDS; ph++) begin
            no_idle = (ph >= 6 && ph < 10);
            write_reg(CFG_LINE_WIDTH, pick_width());
            write_reg(CFG_DIFF_LIMIT,
                      CFG_DATA_W'(($urandom_range(0, 7) << 8) | pick_limit()));
            repeat ($urandom_range(1, 4)) random_frame();
            settle();
        end
        no_idle = 1'b0;

        repeat (16) @(posedge aclk);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
